FILE: design/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

    // Widths of the transaction fields
    localparam int unsigned MODE_W    = 1;
    localparam int unsigned REQ_W     = 11;
    localparam int unsigned TARGET_W  = 6;
    localparam int unsigned OUTCOME_W = 3;
    localparam int unsigned GRANT_W   = 6;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_DONE     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NOFIT    = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NOBLOCK  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_NOTTAKEN = 3'd4;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        S_INIT     = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_SCAN_RD  = 12'b0000_0000_0100,
        S_SCAN_EV  = 12'b0000_0000_1000,
        S_SHIFT_RD = 12'b0000_0001_0000,
        S_SHIFT_WR = 12'b0000_0010_0000,
        S_SPLIT_B  = 12'b0000_0100_0000,
        S_SPLIT_A  = 12'b0000_1000_0000,
        S_FREE_CHK = 12'b0001_0000_0000,
        S_CO_RD    = 12'b0010_0000_0000,
        S_CO_EV    = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

endpackage

FILE: design/ffa_if.sv
`timescale 1ns / 1ps

interface ffa_req_if
    import ffa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [REQ_W-1:0]    request_bytes;
    logic [TARGET_W-1:0] target_block;

    modport source (output valid, mode, request_bytes, target_block, input ready);
    modport sink   (input valid, mode, request_bytes, target_block, output ready);
endinterface

interface ffa_rsp_if
    import ffa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [GRANT_W-1:0]   granted_block;

    modport source (output valid, outcome, granted_block, input ready);
    modport sink   (input valid, outcome, granted_block, output ready);
endinterface

FILE: design/ffa_mem.sv
`timescale 1ns / 1ps

module ffa_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: design/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Port    Direction  Fields
// request   i_req   sink       mode, request_bytes, target_block
// response  o_rsp   source     outcome, granted_block
//
// Allocate: scans blocks in order; a whole-block grant marks it taken; a split
//   shifts later entries up and writes the remainder; no fit ends past the table.
// Free: a taken block starts a compaction pass that merges free runs; a rejected
//   free stops at the bound check or on reading a free block.
// Reset: the init state after reset writes the initial free block; ready stays low.
// A finished result waits in the output register; a new request is taken
//   meanwhile, and the next result waits until that register is emptied.

module first_fit_block_allocator_top
    import ffa_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 1024,
    parameter int unsigned HEADER_BYTES = 12,
    parameter int unsigned MAX_BLOCKS   = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);

    localparam int unsigned BYTES_W = $clog2(HEAP_BYTES + 1);
    localparam int unsigned ENT_W   = BYTES_W + 1;
    localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CMP_W   = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
    localparam int unsigned SUM_W   = ((BYTES_W > REQ_W) ? BYTES_W : REQ_W) + 2;

    localparam logic [BYTES_W-1:0] INIT_BYTES = BYTES_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [BYTES_W-1:0] HDR        = BYTES_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]   HDR_X      = SUM_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_BLOCKS);

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_wp, n_wp;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [BYTES_W-1:0]   r_bytes, n_bytes;
    logic [REQ_W-1:0]     r_req, n_req;
    logic [TARGET_W-1:0]  r_target, n_target;
    logic [ENT_W-1:0]     r_acc, n_acc;
    logic                 r_acc_ok, n_acc_ok;
    logic [OUTCOME_W-1:0] r_res_outcome, n_res_outcome;
    logic [GRANT_W-1:0]   r_res_grant, n_res_grant;
    logic                 r_out_valid, n_out_valid;
    logic [OUTCOME_W-1:0] r_out_outcome, n_out_outcome;
    logic [GRANT_W-1:0]   r_out_grant, n_out_grant;

    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic [ENT_W-1:0]   rd_data, wr_data;
    logic               rd_taken, ev_taken;
    logic [BYTES_W-1:0] rd_bytes;
    logic [SUM_W-1:0]   bytes_x, req_x;
    logic               accept;

    ffa_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ENT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign rd_taken = rd_data[BYTES_W];
    assign rd_bytes = rd_data[BYTES_W-1:0];
    assign bytes_x  = SUM_W'(rd_bytes);
    assign req_x    = SUM_W'(r_req);
    // The block being freed reads as free during the compaction pass
    assign ev_taken = rd_taken && (CMP_W'(r_ptr) != CMP_W'(r_target));

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.outcome       = r_out_outcome;
    assign o_rsp.granted_block = r_out_grant;

    // Sequence scan, shift and compaction through the block RAM
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_wp          = r_wp;
        n_idx         = r_idx;
        n_bytes       = r_bytes;
        n_req         = r_req;
        n_target      = r_target;
        n_acc         = r_acc;
        n_acc_ok      = r_acc_ok;
        n_res_outcome = r_res_outcome;
        n_res_grant   = r_res_grant;
        n_out_valid   = r_out_valid;
        n_out_outcome = r_out_outcome;
        n_out_grant   = r_out_grant;
        rd_en         = 1'b0;
        rd_addr       = r_ptr[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = r_ptr[IDX_W-1:0];
        wr_data       = rd_data;

        // Drop the result once the sink takes it
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b0, INIT_BYTES};
                n_count = CNT_W'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_req         = i_req.request_bytes;
                    n_target      = i_req.target_block;
                    n_ptr         = '0;
                    n_res_outcome = OUT_DONE;
                    n_res_grant   = '0;
                    if (i_req.mode == MODE_ALLOC) begin
                        n_state = S_SCAN_RD;
                    end else if (CMP_W'(i_req.target_block) >= CMP_W'(r_count)) begin
                        n_res_outcome = OUT_NOBLOCK;
                        n_state       = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(i_req.target_block);
                        n_state = S_FREE_CHK;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_ptr >= r_count) begin
                    n_res_outcome = OUT_NOFIT;
                    n_state       = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (!rd_taken && bytes_x >= req_x) begin
                    n_idx   = r_ptr[IDX_W-1:0];
                    n_bytes = rd_bytes;
                    if (bytes_x == req_x || bytes_x < req_x + HDR_X) begin
                        // Give the whole block unsplit
                        wr_en         = 1'b1;
                        wr_data       = {1'b1, rd_bytes};
                        n_res_grant   = GRANT_W'(r_ptr);
                        n_state       = S_DONE;
                    end else if (r_count >= MAX_CNT) begin
                        n_res_outcome = OUT_FULL;
                        n_state       = S_DONE;
                    end else begin
                        n_ptr   = r_count;
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    n_ptr   = r_ptr + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_ptr > CNT_W'(r_idx) + CNT_W'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_ptr - CNT_W'(1));
                    n_state = S_SHIFT_WR;
                end else begin
                    n_state = S_SPLIT_B;
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                n_ptr   = r_ptr - CNT_W'(1);
                n_state = S_SHIFT_RD;
            end
            S_SPLIT_B: begin
                // Insert the free remainder after the split block
                wr_en   = 1'b1;
                wr_addr = r_idx + IDX_W'(1);
                wr_data = {1'b0, BYTES_W'(r_bytes - BYTES_W'(r_req) - HDR)};
                n_state = S_SPLIT_A;
            end
            S_SPLIT_A: begin
                wr_en       = 1'b1;
                wr_addr     = r_idx;
                wr_data     = {1'b1, BYTES_W'(r_req)};
                n_count     = r_count + CNT_W'(1);
                n_res_grant = GRANT_W'(r_idx);
                n_state     = S_DONE;
            end
            S_FREE_CHK: begin
                if (!rd_taken) begin
                    n_res_outcome = OUT_NOTTAKEN;
                    n_state       = S_DONE;
                end else begin
                    n_ptr    = '0;
                    n_wp     = '0;
                    n_acc_ok = 1'b0;
                    n_state  = S_CO_RD;
                end
            end
            S_CO_RD: begin
                if (r_ptr >= r_count) begin
                    // Flush the last merged block and close the table
                    wr_en   = 1'b1;
                    wr_addr = r_wp[IDX_W-1:0];
                    wr_data = r_acc;
                    n_count = r_wp + CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CO_EV;
                end
            end
            S_CO_EV: begin
                if (!r_acc_ok) begin
                    n_acc    = {ev_taken, rd_bytes};
                    n_acc_ok = 1'b1;
                end else if (!r_acc[BYTES_W] && !ev_taken) begin
                    n_acc = {1'b0, BYTES_W'(r_acc[BYTES_W-1:0] + rd_bytes + HDR)};
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_wp[IDX_W-1:0];
                    wr_data = r_acc;
                    n_wp    = r_wp + CNT_W'(1);
                    n_acc   = {ev_taken, rd_bytes};
                end
                n_ptr   = r_ptr + CNT_W'(1);
                n_state = S_CO_RD;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_outcome = r_res_outcome;
                    n_out_grant   = r_res_grant;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_wp          <= n_wp;
        r_idx         <= n_idx;
        r_bytes       <= n_bytes;
        r_req         <= n_req;
        r_target      <= n_target;
        r_acc         <= n_acc;
        r_acc_ok      <= n_acc_ok;
        r_res_outcome <= n_res_outcome;
        r_res_grant   <= n_res_grant;
        r_out_outcome <= n_out_outcome;
        r_out_grant   <= n_out_grant;
    end

endmodule

FILE: design/ffa_chk.sv
`timescale 1ns / 1ps

module ffa_chk
    import ffa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [OUTCOME_W-1:0] i_outcome,
    input logic [GRANT_W-1:0]   i_granted
);

    // Hold a pending response until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    // Keep the outcome within its codes
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_outcome == OUT_DONE || i_outcome == OUT_NOFIT ||
                         i_outcome == OUT_FULL || i_outcome == OUT_NOBLOCK ||
                         i_outcome == OUT_NOTTAKEN))
        else $error("outcome code out of range");

    // Zero the granted index on every failed request
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outcome != OUT_DONE |-> i_granted == '0)
        else $error("granted index set on failure");

    // Refuse requests in the cycle after reset while the table initializes
    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during table initialization");

endmodule

bind first_fit_block_allocator_top ffa_chk u_ffa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_outcome   (o_rsp.outcome),
    .i_granted   (o_rsp.granted_block)
);

FILE: dv/first_fit_block_allocator_top_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_top_test
    import ffa_pkg::*;
();

    localparam int unsigned HEAP_BYTES   = 1024;
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned MAX_BLOCKS   = 64;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [GRANT_W-1:0]   granted_block;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    ffa_req_if req_if ();
    ffa_rsp_if rsp_if ();

    first_fit_block_allocator_top #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // Shadow heap table
    int unsigned heap_bytes [MAX_BLOCKS];
    bit          heap_taken [MAX_BLOCKS];
    int unsigned heap_count;

    t_result pending_results [$];
    int      error_count;
    bit      hold_off;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void heap_reset();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            heap_bytes[k] = 0;
            heap_taken[k] = 0;
        end
        heap_bytes[0] = HEAP_BYTES - HEADER_BYTES;
        heap_count    = 1;
    endfunction

    // Merge every run of adjacent free blocks
    function automatic void heap_merge();
        int unsigned k;
        k = 0;
        while (k + 1 < heap_count) begin
            if (!heap_taken[k] && !heap_taken[k+1]) begin
                heap_bytes[k] += heap_bytes[k+1] + HEADER_BYTES;
                for (int j = k + 1; j + 1 < heap_count; j++) begin
                    heap_bytes[j] = heap_bytes[j+1];
                    heap_taken[j] = heap_taken[j+1];
                end
                heap_count--;
                heap_bytes[heap_count] = 0;
                heap_taken[heap_count] = 0;
            end else begin
                k++;
            end
        end
    endfunction

    function automatic t_result predict_heap_op(logic [MODE_W-1:0] mode,
                                                logic [REQ_W-1:0] req,
                                                logic [TARGET_W-1:0] tgt);
        t_result     res;
        int unsigned k;
        res.outcome       = OUT_DONE;
        res.granted_block = '0;
        if (mode == MODE_ALLOC) begin
            k = 0;
            while (k < heap_count && (heap_taken[k] || heap_bytes[k] < req)) k++;
            if (k >= heap_count) begin
                res.outcome = OUT_NOFIT;
            end else if (heap_bytes[k] == req || heap_bytes[k] < req + HEADER_BYTES) begin
                heap_taken[k]     = 1;
                res.granted_block = k[GRANT_W-1:0];
            end else if (heap_count >= MAX_BLOCKS) begin
                res.outcome = OUT_FULL;
            end else begin
                for (int j = heap_count; j > k + 1; j--) begin
                    heap_bytes[j] = heap_bytes[j-1];
                    heap_taken[j] = heap_taken[j-1];
                end
                heap_bytes[k+1]   = heap_bytes[k] - req - HEADER_BYTES;
                heap_taken[k+1]   = 0;
                heap_bytes[k]     = req;
                heap_taken[k]     = 1;
                heap_count++;
                res.granted_block = k[GRANT_W-1:0];
            end
        end else begin
            if (tgt >= heap_count) begin
                res.outcome = OUT_NOBLOCK;
            end else if (!heap_taken[tgt]) begin
                res.outcome = OUT_NOTTAKEN;
            end else begin
                heap_taken[tgt] = 0;
                heap_merge();
            end
        end
        return res;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(logic [MODE_W-1:0] mode, logic [REQ_W-1:0] req,
                                logic [TARGET_W-1:0] tgt);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // Keep valid high across back-to-back transactions
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.request_bytes <= req;
        req_if.target_block  <= tgt;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_heap_op(mode, req, tgt));
    endtask

    task automatic alloc_req(int unsigned bytes);
        send_request(MODE_ALLOC, bytes[REQ_W-1:0], TARGET_W'($urandom));
    endtask

    task automatic free_req(int unsigned idx);
        send_request(MODE_FREE, REQ_W'($urandom), idx[TARGET_W-1:0]);
    endtask

    // Check each response against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response outcome=%0d granted=%0d", $time,
                         rsp_if.outcome, rsp_if.granted_block);
                error_count++;
            end else begin
                t_result exp_res;
                exp_res = pending_results.pop_front();
                if (rsp_if.outcome !== exp_res.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             exp_res.outcome, rsp_if.outcome);
                    error_count++;
                end
                if (rsp_if.granted_block !== exp_res.granted_block) begin
                    $display("%0t: granted_block expected %0d actual %0d", $time,
                             exp_res.granted_block, rsp_if.granted_block);
                    error_count++;
                end
            end
        end
    end

    // Response side stalls, with a long hold-off on request
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                rsp_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            if (stall == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end
        end
    end

    task automatic test_directed_edges();
        alloc_req(0);                       // zero-size split
        alloc_req(HEAP_BYTES);              // no fit above heap
        alloc_req(11'h7FF);                 // all request bits set
        free_req(63);                       // no such block
        free_req(1);                        // free block, not allocated
        free_req(0);                        // free, merge with neighbor
        alloc_req(1000);                    // fits, split with zero remainder
        alloc_req(1);                       // no fit while heap taken
        free_req(0);
        alloc_req(HEAP_BYTES - HEADER_BYTES); // exact fit
        free_req(0);
        alloc_req(HEAP_BYTES - 2*HEADER_BYTES); // zero remainder
        free_req(0);
        alloc_req(100);
        alloc_req(200);
        alloc_req(50);
        free_req(1);
        free_req(0);                        // merge of two
        free_req(2);
        free_req(0);
        free_req(42);                       // index bits toward top
        free_req(21);
    endtask

    // Many zero-size splits fill the table
    task automatic test_table_full();
        for (int k = 0; k < 66; k++) alloc_req(0);
        alloc_req(5);
        for (int k = 0; k < 66; k++) free_req($urandom_range(0, 63));
        for (int k = 0; k < 70; k++) free_req(k % 64);
    endtask

    // Rest of heap offered while the response side holds off
    task automatic test_backpressure();
        hold_off = 1;
        for (int k = 0; k < 20; k++) alloc_req($urandom_range(0, 40));
        for (int k = 0; k < 20; k++) free_req(k);
    endtask

    task automatic test_random_traffic();
        int unsigned bytes;
        for (int n = 0; n < 640; n++) begin
            case ($urandom_range(0, 9))
                0: alloc_req($urandom_range(0, 2047));
                1, 2: free_req($urandom);
                3, 4, 5: free_req($urandom_range(0, heap_count));
                default: begin
                    bytes = $urandom_range(0, 3) == 0 ? $urandom_range(0, 400)
                                                      : $urandom_range(0, 48);
                    alloc_req(bytes);
                end
            endcase
        end
    endtask

    initial begin
        error_count = 0;
        hold_off    = 0;
        heap_reset();
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= MODE_ALLOC;
        req_if.request_bytes <= '0;
        req_if.target_block  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_table_full();
        test_backpressure();
        test_random_traffic();

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
